// File: rtl/core/cbhe_pkg.sv
package cbhe_pkg;

   // Opcodes
   localparam logic [3:0] OP_UNSIGNED = 4'd0;
   localparam logic [3:0] OP_NEGATIVE = 4'd1;
   localparam logic [3:0] OP_BYTES    = 4'd2;
   localparam logic [3:0] OP_TEXT     = 4'd3;
   localparam logic [3:0] OP_ARRAY    = 4'd4;
   localparam logic [3:0] OP_MAP      = 4'd5;
   localparam logic [3:0] OP_TAG      = 4'd6;
   localparam logic [3:0] OP_BOOL     = 4'd7;
   localparam logic [3:0] OP_NULL     = 4'd8;
   localparam logic [3:0] OP_PAYLOAD  = 4'd9;

   // Additional-information codes of the initial byte
   localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
   localparam logic [4:0] AI_TWO_BYTE   = 5'd25;
   localparam logic [4:0] AI_FOUR_BYTE  = 5'd26;
   localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;

   // Simple values
   localparam logic [7:0] SIMPLE_TRUE  = 8'hF5;
   localparam logic [7:0] SIMPLE_FALSE = 8'hF4;
   localparam logic [7:0] SIMPLE_NULL  = 8'hF6;

   // Default depth of the descriptor queue
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [63:0] argument;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Work handed from front to back: initial byte, argument byte count, argument
   typedef struct packed {
      logic [7:0]  init_byte;
      logic [3:0]  nbytes;
      logic [63:0] arg;
   } desc_type;

endpackage

// File: rtl/core/cbhe_front.sv
module cbhe_front (
   input  cbhe_pkg::req_type  req_data,
   output logic               desc_valid,
   output cbhe_pkg::desc_type desc
);

   logic [63:0] value;
   logic [2:0]  major;

   // Negative opcode encodes the plain negation of the argument
   assign value = (req_data.opcode == cbhe_pkg::OP_NEGATIVE) ?
                  (64'd0 - req_data.argument) : req_data.argument;
   assign major = req_data.opcode[2:0];

   // Classify the beat and build the initial byte plus argument length
   always_comb begin
      desc_valid     = 1'b1;
      desc.init_byte = 8'h00;
      desc.nbytes    = 4'd0;
      desc.arg       = value;
      case (req_data.opcode)
         cbhe_pkg::OP_UNSIGNED, cbhe_pkg::OP_NEGATIVE, cbhe_pkg::OP_BYTES,
         cbhe_pkg::OP_TEXT, cbhe_pkg::OP_ARRAY, cbhe_pkg::OP_MAP,
         cbhe_pkg::OP_TAG: begin
            if (value < 64'd24) begin
               desc.init_byte = {major, value[4:0]};
            end else if (value <= 64'hFF) begin
               desc.init_byte = {major, cbhe_pkg::AI_ONE_BYTE};
               desc.nbytes    = 4'd1;
            end else if (value <= 64'hFFFF) begin
               desc.init_byte = {major, cbhe_pkg::AI_TWO_BYTE};
               desc.nbytes    = 4'd2;
            end else if (value <= 64'hFFFF_FFFF) begin
               desc.init_byte = {major, cbhe_pkg::AI_FOUR_BYTE};
               desc.nbytes    = 4'd4;
            end else begin
               desc.init_byte = {major, cbhe_pkg::AI_EIGHT_BYTE};
               desc.nbytes    = 4'd8;
            end
         end
         cbhe_pkg::OP_BOOL: begin
            desc.init_byte = (|req_data.argument) ? cbhe_pkg::SIMPLE_TRUE
                                                  : cbhe_pkg::SIMPLE_FALSE;
         end
         cbhe_pkg::OP_NULL: begin
            desc.init_byte = cbhe_pkg::SIMPLE_NULL;
         end
         cbhe_pkg::OP_PAYLOAD: begin
            desc.init_byte = req_data.data_byte;
         end
         default: begin
            // unused opcodes are dropped
            desc_valid = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/core/cbhe_queue.sv
module cbhe_queue #(
   parameter int Depth = cbhe_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cbhe_pkg::desc_type push_desc,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output cbhe_pkg::desc_type head_desc
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   cbhe_pkg::desc_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign not_full  = (count_ff != CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head_desc = entries_ff[rd_ptr_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: rtl/core/cbhe_back.sv
module cbhe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cbhe_pkg::desc_type q_desc,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cbhe_pkg::rsp_type  rsp_data
);

   logic               busy_ff, busy_in;
   logic [3:0]         rem_ff, rem_in;
   logic [63:0]        arg_ff, arg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cbhe_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic               out_free;
   logic [2:0]         byte_idx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = out_free && !busy_ff && q_valid;
   assign byte_idx  = 3'(rem_ff - 4'd1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Serializer: initial byte from the queue, then argument bytes MSB first
   always_comb begin
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      arg_in       = arg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (busy_ff) begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.out_byte = arg_ff[{byte_idx, 3'b000} +: 8];
            rsp_data_in.last     = (rem_ff == 4'd1);
            rem_in               = rem_ff - 4'd1;
            busy_in              = (rem_ff != 4'd1);
         end else if (q_valid) begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.out_byte = q_desc.init_byte;
            rsp_data_in.last     = (q_desc.nbytes == 4'd0);
            rem_in               = q_desc.nbytes;
            arg_in               = q_desc.arg;
            busy_in              = (q_desc.nbytes != 4'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      arg_ff      <= arg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/core/cbor_head_encoder_top.sv
// CBOR head encoder.
// Request channel (req_valid/req_ready/req_data) takes one beat per item:
// an opcode with a 64-bit argument or a raw payload byte. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns the encoded bytes one per beat,
// with last set on the final byte of each item; unused opcodes give none.
// The first byte of an item is written into the descriptor queue and then
// registered in the output stage before it is valid on rsp_data.
// Single-byte items (small values, bool, null, payload) sustain one item
// per cycle while rsp_ready stays high. A header item with an N-byte
// argument (N = 1, 2, 4 or 8) occupies the output serializer for its initial
// byte and its N argument bytes; that serializer sets the rate for header items.
// A QueueDepth-entry descriptor queue sits between the classifier and the
// serializer, so requests keep flowing while the serializer drains.
// When the receiver stalls, the pending byte holds on rsp_data, the queue
// fills and req_ready drops. Reset clears the queue and the output stage;
// the block accepts a beat in the first cycle after reset.
module cbor_head_encoder_top #(
   parameter int QueueDepth = cbhe_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbhe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbhe_pkg::rsp_type rsp_data
);

   logic               front_valid;
   cbhe_pkg::desc_type front_desc;
   logic               q_not_empty;
   logic               q_pop;
   cbhe_pkg::desc_type q_head;

   cbhe_front u_front (
      .req_data   (req_data),
      .desc_valid (front_valid),
      .desc       (front_desc)
   );

   cbhe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && front_valid),
      .push_desc (front_desc),
      .not_full  (req_ready),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_desc (q_head)
   );

   cbhe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_desc    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/cbhe_checker.sv
module cbhe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input cbhe_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cbhe_pkg::rsp_type rsp_data
);

   // Stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed under stall");

   // Output stage is empty right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Argument bytes follow the initial byte without gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("gap inside an encoded item");

   // Payload beat into an idle block comes out as that byte, last set
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == cbhe_pkg::OP_PAYLOAD &&
      !rsp_valid && $past(!req_valid) && !$past(reset) && $past(!rsp_valid, 2)
      |-> ##2 rsp_valid && rsp_data.last && rsp_data.out_byte == $past(req_data.data_byte, 2))
      else $error("payload byte not passed through");

endmodule

bind cbor_head_encoder_top cbhe_checker u_cbhe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
